@@ rtl/prc_pkg.sv @@
package prc_pkg;

  // field and port geometry
  localparam int FIELD_W = 32;
  localparam int IN_FIELDS = 5;
  localparam int OUT_FIELDS = 3;

  // defaults for the top level parameters
  localparam int ANGLE_BITS_DEF = 32;
  localparam int COORD_FRAC_BITS_DEF = 30;

  // cordic and pipeline structure
  localparam int CORDIC_STEPS = 32;
  localparam int QUEUE_DEPTH = 4;
  localparam int NUM_ROT = 8;
  localparam int SC_LAT = CORDIC_STEPS + 2;
  localparam int VEC_LAT = CORDIC_STEPS + 1;
  localparam int MUL_LAT = 2;
  localparam int ROT_LAT = MUL_LAT + 1;

  // plane of each rotation in chain order, set bit means xy, clear means xz
  localparam logic [NUM_ROT-1:0] ROT_XY = 8'b1010_1001;

  // arctangent of 2^-i as a 32-bit binary angle
  localparam logic [31:0] ATAN_Q32 [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  // inverse cordic gain in q0.32
  localparam logic [31:0] INV_GAIN_Q32 = 32'h9B74EDA8;

  // bring a 32-bit fraction to another resolution, round half up when narrowing
  function automatic logic [63:0] rescale32(logic [31:0] v, int bits);
    logic [63:0] w;
    w = {32'd0, v};
    if (bits >= 32) begin
      return w << (bits - 32);
    end
    return (w + (64'd1 << (31 - bits))) >> (32 - bits);
  endfunction

endpackage

@@ rtl/prc_front.sv @@
module prc_front #(
  parameter int ANGLE_BITS = prc_pkg::ANGLE_BITS_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          in_valid,
  output logic                                          in_ready,
  input  logic [prc_pkg::IN_FIELDS*prc_pkg::FIELD_W-1:0] in_data,
  input  logic                                          pop,
  output logic                                          head_valid,
  output logic [ANGLE_BITS-1:0]                         polar,
  output logic [ANGLE_BITS-1:0]                         azimuth,
  output logic [ANGLE_BITS-1:0]                         prec_open_neg,
  output logic [ANGLE_BITS-1:0]                         prec_phase_neg,
  output logic [ANGLE_BITS-1:0]                         spin_phase_neg
);
  import prc_pkg::*;

  localparam int A = ANGLE_BITS;
  localparam int D = QUEUE_DEPTH;
  localparam int PW = (D > 1) ? $clog2(D) : 1;
  localparam int CNW = $clog2(D + 1);
  localparam int EW = IN_FIELDS * A;

  logic [EW-1:0]  mem [D];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CNW-1:0] count;
  logic [A-1:0]   ang [IN_FIELDS];
  logic [EW-1:0]  entry;
  logic [EW-1:0]  head;
  logic           push;
  logic           do_pop;

  // fields to angles, negating the ones the chain turns backwards by
  always_comb begin
    for (int k = 0; k < IN_FIELDS; k++) begin
      ang[k] = A'($signed(in_data[k*FIELD_W +: FIELD_W]));
    end
    entry = {A'(-ang[4]), A'(-ang[3]), A'(-ang[2]), ang[1], ang[0]};
  end

  assign in_ready   = count < CNW'(D);
  assign head_valid = count != '0;
  assign push       = in_valid & in_ready;
  assign do_pop     = pop & head_valid;

  // item queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= entry;
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(D - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(D - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  // head of queue
  assign head           = mem[rd_ptr];
  assign polar          = head[0*A +: A];
  assign azimuth        = head[1*A +: A];
  assign prec_open_neg  = head[2*A +: A];
  assign prec_phase_neg = head[3*A +: A];
  assign spin_phase_neg = head[4*A +: A];

endmodule

@@ rtl/prc_pipe.sv @@
module prc_pipe #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] stage [N];

  // delay line that advances with the pipeline
  always_ff @(posedge clk) begin
    if (en) begin
      stage[0] <= d;
      for (int i = 1; i < N; i++) begin
        stage[i] <= stage[i-1];
      end
    end
  end

  assign q = stage[N-1];

endmodule

@@ rtl/prc_mul.sv @@
module prc_mul #(
  parameter int COORD_FRAC_BITS = prc_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [COORD_FRAC_BITS+3:0] a,
  input  logic signed [COORD_FRAC_BITS+3:0] b,
  output logic signed [COORD_FRAC_BITS+3:0] p
);

  localparam int F = COORD_FRAC_BITS;
  localparam int CW = F + 4;

  logic [CW-1:0]   ua;
  logic [CW-1:0]   ub;
  logic [2*CW-1:0] prod;
  logic [2*CW-1:0] rnd;
  logic [CW-1:0]   mag;
  logic            neg;

  // magnitudes
  assign ua = a[CW-1] ? CW'(-a) : CW'(a);
  assign ub = b[CW-1] ? CW'(-b) : CW'(b);

  // product of magnitudes
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= ua * ub;
      neg  <= a[CW-1] ^ b[CW-1];
    end
  end

  // round to nearest, ties away from zero, then restore sign
  assign rnd = prod + ((2 * CW)'(1) << (F - 1));
  assign mag = rnd[F +: CW];

  always_ff @(posedge clk) begin
    if (en) begin
      p <= neg ? -$signed(mag) : $signed(mag);
    end
  end

endmodule

@@ rtl/prc_sincos.sv @@
module prc_sincos #(
  parameter int ANGLE_BITS      = prc_pkg::ANGLE_BITS_DEF,
  parameter int COORD_FRAC_BITS = prc_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic [ANGLE_BITS-1:0]             ang,
  output logic signed [COORD_FRAC_BITS+3:0] c,
  output logic signed [COORD_FRAC_BITS+3:0] s
);
  import prc_pkg::*;

  localparam int A = ANGLE_BITS;
  localparam int F = COORD_FRAC_BITS;
  localparam int CW = F + 4;
  localparam int ZW = A + 2;
  localparam int N = CORDIC_STEPS;
  localparam logic signed [ZW-1:0] QTR  = ZW'(64'd1 << (A - 2));
  localparam logic signed [ZW-1:0] HALF = ZW'(64'd1 << (A - 1));
  localparam logic signed [CW-1:0] ONE  = CW'(64'd1 << F);
  localparam logic signed [CW-1:0] XINIT = CW'(rescale32(INV_GAIN_Q32, F));

  logic signed [CW-1:0] xs [N+1];
  logic signed [CW-1:0] ys [N+1];
  logic signed [ZW-1:0] zs [N+1];
  logic                 fl [N+1];
  logic signed [ZW-1:0] za;
  logic signed [ZW-1:0] z0;
  logic                 f0;
  logic signed [CW-1:0] xf;
  logic signed [CW-1:0] yf;

  // fold angles past a quarter turn by a half turn
  always_comb begin
    za = ZW'($signed(ang));
    if (za > QTR) begin
      z0 = za - HALF;
      f0 = 1'b1;
    end else if (za < -QTR) begin
      z0 = za + HALF;
      f0 = 1'b1;
    end else begin
      z0 = za;
      f0 = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xs[0] <= XINIT;
      ys[0] <= '0;
      zs[0] <= z0;
      fl[0] <= f0;
    end
  end

  // one rotation-mode micro-rotation per stage
  for (genvar i = 0; i < N; i++) begin : g_step
    localparam logic signed [ZW-1:0] STEP = ZW'(rescale32(ATAN_Q32[i], A));
    always_ff @(posedge clk) begin
      if (en) begin
        if (zs[i] >= 0) begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - STEP;
        end else begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + STEP;
        end
        fl[i+1] <= fl[i];
      end
    end
  end

  // undo the fold and clamp to the unit range
  assign xf = fl[N] ? -xs[N] : xs[N];
  assign yf = fl[N] ? -ys[N] : ys[N];

  always_ff @(posedge clk) begin
    if (en) begin
      if (xf > ONE) begin
        c <= ONE;
      end else if (xf < -ONE) begin
        c <= -ONE;
      end else begin
        c <= xf;
      end
      if (yf > ONE) begin
        s <= ONE;
      end else if (yf < -ONE) begin
        s <= -ONE;
      end else begin
        s <= yf;
      end
    end
  end

endmodule

@@ rtl/prc_vec.sv @@
module prc_vec #(
  parameter int ANGLE_BITS      = prc_pkg::ANGLE_BITS_DEF,
  parameter int COORD_FRAC_BITS = prc_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [COORD_FRAC_BITS+3:0] x,
  input  logic signed [COORD_FRAC_BITS+3:0] y,
  output logic signed [COORD_FRAC_BITS+3:0] mag,
  output logic signed [ANGLE_BITS+1:0]      ang
);
  import prc_pkg::*;

  localparam int A = ANGLE_BITS;
  localparam int F = COORD_FRAC_BITS;
  localparam int CW = F + 4;
  localparam int ZW = A + 2;
  localparam int N = CORDIC_STEPS;
  localparam logic signed [ZW-1:0] QTR = ZW'(64'd1 << (A - 2));

  logic signed [CW-1:0] xs [N+1];
  logic signed [CW-1:0] ys [N+1];
  logic signed [ZW-1:0] zs [N+1];

  // left half-plane inputs are first turned by a quarter
  always_ff @(posedge clk) begin
    if (en) begin
      if (x < 0) begin
        if (y >= 0) begin
          xs[0] <= y;
          ys[0] <= -x;
          zs[0] <= QTR;
        end else begin
          xs[0] <= -y;
          ys[0] <= x;
          zs[0] <= -QTR;
        end
      end else begin
        xs[0] <= x;
        ys[0] <= y;
        zs[0] <= '0;
      end
    end
  end

  // one vectoring micro-rotation per stage
  for (genvar i = 0; i < N; i++) begin : g_step
    localparam logic signed [ZW-1:0] STEP = ZW'(rescale32(ATAN_Q32[i], A));
    always_ff @(posedge clk) begin
      if (en) begin
        if (ys[i] >= 0) begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + STEP;
        end else begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - STEP;
        end
      end
    end
  end

  assign mag = xs[N];
  assign ang = zs[N];

endmodule

@@ rtl/prc_rot.sv @@
module prc_rot #(
  parameter int COORD_FRAC_BITS = prc_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [COORD_FRAC_BITS+3:0] u,
  input  logic signed [COORD_FRAC_BITS+3:0] w,
  input  logic signed [COORD_FRAC_BITS+3:0] c,
  input  logic signed [COORD_FRAC_BITS+3:0] s,
  output logic signed [COORD_FRAC_BITS+3:0] nu,
  output logic signed [COORD_FRAC_BITS+3:0] nw
);

  localparam int F = COORD_FRAC_BITS;
  localparam int CW = F + 4;
  localparam logic signed [CW-1:0] ONE = CW'(64'd1 << F);

  logic signed [CW-1:0] cu;
  logic signed [CW-1:0] sw;
  logic signed [CW-1:0] cw;
  logic signed [CW-1:0] su;
  logic signed [CW:0]   sum_u;
  logic signed [CW:0]   sum_w;

  // four rounded products
  prc_mul #(.COORD_FRAC_BITS(F)) u_cu (.clk(clk), .en(en), .a(c), .b(u), .p(cu));
  prc_mul #(.COORD_FRAC_BITS(F)) u_sw (.clk(clk), .en(en), .a(s), .b(w), .p(sw));
  prc_mul #(.COORD_FRAC_BITS(F)) u_cw (.clk(clk), .en(en), .a(c), .b(w), .p(cw));
  prc_mul #(.COORD_FRAC_BITS(F)) u_su (.clk(clk), .en(en), .a(s), .b(u), .p(su));

  assign sum_u = cu + sw;
  assign sum_w = cw - su;

  // combine and clamp to the unit range
  always_ff @(posedge clk) begin
    if (en) begin
      if (sum_u > ONE) begin
        nu <= ONE;
      end else if (sum_u < -ONE) begin
        nu <= -ONE;
      end else begin
        nu <= sum_u[CW-1:0];
      end
      if (sum_w > ONE) begin
        nw <= ONE;
      end else if (sum_w < -ONE) begin
        nw <= -ONE;
      end else begin
        nw <= sum_w[CW-1:0];
      end
    end
  end

endmodule

@@ rtl/prc_back.sv @@
module prc_back #(
  parameter int ANGLE_BITS      = prc_pkg::ANGLE_BITS_DEF,
  parameter int COORD_FRAC_BITS = prc_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [ANGLE_BITS-1:0]         spin_open_neg,
  input  logic                          head_valid,
  output logic                          pop,
  input  logic [ANGLE_BITS-1:0]         polar,
  input  logic [ANGLE_BITS-1:0]         azimuth,
  input  logic [ANGLE_BITS-1:0]         prec_open_neg,
  input  logic [ANGLE_BITS-1:0]         prec_phase_neg,
  input  logic [ANGLE_BITS-1:0]         spin_phase_neg,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [prc_pkg::FIELD_W-1:0]   vec_x,
  output logic [prc_pkg::FIELD_W-1:0]   vec_y,
  output logic [prc_pkg::FIELD_W-1:0]   vec_z
);
  import prc_pkg::*;

  localparam int A = ANGLE_BITS;
  localparam int F = COORD_FRAC_BITS;
  localparam int CW = F + 4;
  localparam int ZW = A + 2;
  localparam int LS = SC_LAT;
  localparam int LV = VEC_LAT;
  localparam int LM = MUL_LAT;
  localparam int LR = ROT_LAT;
  // delay from item entry until the reference angle is ready
  localparam int T0 = LS + LM + LV + LM + LV;
  localparam int LAT = T0 + LS + NUM_ROT * LR;
  localparam logic [A-1:0] QTR = A'(64'd1 << (A - 2));
  localparam logic signed [CW-1:0] INVK = CW'(rescale32(INV_GAIN_Q32, F));

  logic                 en;
  logic [LAT-1:0]       vld;
  logic signed [CW-1:0] ct, st, cp, sp;
  logic signed [CW-1:0] x0, y0, z2;
  logic signed [CW-1:0] x_v2, y_t0, r_raw, r_cor;
  logic signed [ZW-1:0] ang_v1, ang_v2;
  logic signed [CW-1:0] mag_v2;
  logic [A-1:0]         rel;
  logic [A-1:0]         rel_neg;
  logic [A-1:0]         rot_ang [NUM_ROT];
  logic signed [CW-1:0] rc [NUM_ROT];
  logic signed [CW-1:0] rs [NUM_ROT];
  logic signed [CW-1:0] vx [NUM_ROT+1];
  logic signed [CW-1:0] vy [NUM_ROT+1];
  logic signed [CW-1:0] vz [NUM_ROT+1];

  // the whole chain advances unless a finished result is held
  assign en        = !out_valid || out_ready;
  assign pop       = head_valid && en;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], pop};
    end
  end

  // unit vector from the sun angles
  prc_sincos #(.ANGLE_BITS(A), .COORD_FRAC_BITS(F)) u_sc_pol (
    .clk(clk), .en(en), .ang(polar), .c(ct), .s(st));
  prc_sincos #(.ANGLE_BITS(A), .COORD_FRAC_BITS(F)) u_sc_az (
    .clk(clk), .en(en), .ang(azimuth), .c(cp), .s(sp));
  prc_mul #(.COORD_FRAC_BITS(F)) u_mx (.clk(clk), .en(en), .a(st), .b(cp), .p(x0));
  prc_mul #(.COORD_FRAC_BITS(F)) u_my (.clk(clk), .en(en), .a(st), .b(sp), .p(y0));
  prc_pipe #(.W(CW), .N(LM)) u_dz (.clk(clk), .en(en), .d(ct), .q(z2));

  // magnitude of (y, z), gain corrected
  prc_vec #(.ANGLE_BITS(A), .COORD_FRAC_BITS(F)) u_vec1 (
    .clk(clk), .en(en), .x(y0), .y(z2), .mag(r_raw), .ang(ang_v1));
  prc_mul #(.COORD_FRAC_BITS(F)) u_mr (.clk(clk), .en(en), .a(r_raw), .b(INVK), .p(r_cor));
  prc_pipe #(.W(CW), .N(LV + LM)) u_dx1 (.clk(clk), .en(en), .d(x0), .q(x_v2));

  // reference angle as atan2 of (magnitude, x)
  prc_vec #(.ANGLE_BITS(A), .COORD_FRAC_BITS(F)) u_vec2 (
    .clk(clk), .en(en), .x(x_v2), .y(r_cor), .mag(mag_v2), .ang(ang_v2));
  prc_pipe #(.W(CW), .N(2 * LV + LM)) u_dy1 (.clk(clk), .en(en), .d(y0), .q(y_t0));

  // the negative-y half of the sphere takes the angle the other way round
  assign rel     = y_t0[CW-1] ? A'(-ang_v2[A-1:0]) : ang_v2[A-1:0];
  assign rel_neg = A'(-rel);

  // vector waits for the first rotation's sine and cosine
  prc_pipe #(.W(CW), .N(LV + LS)) u_dx2 (.clk(clk), .en(en), .d(x_v2), .q(vx[0]));
  prc_pipe #(.W(CW), .N(LS)) u_dy2 (.clk(clk), .en(en), .d(y_t0), .q(vy[0]));
  prc_pipe #(.W(CW), .N(T0 - LM)) u_dz2 (.clk(clk), .en(en), .d(z2), .q(vz[0]));

  // rotation angles, each timed to meet its rotation
  assign rot_ang[0] = rel;
  assign rot_ang[1] = QTR;
  assign rot_ang[2] = spin_open_neg;
  assign rot_ang[6] = A'(-QTR);
  prc_pipe #(.W(A), .N(T0 + 3 * LR)) u_dsp (
    .clk(clk), .en(en), .d(spin_phase_neg), .q(rot_ang[3]));
  prc_pipe #(.W(A), .N(T0 + 4 * LR)) u_dpo (
    .clk(clk), .en(en), .d(prec_open_neg), .q(rot_ang[4]));
  prc_pipe #(.W(A), .N(T0 + 5 * LR)) u_dpp (
    .clk(clk), .en(en), .d(prec_phase_neg), .q(rot_ang[5]));
  prc_pipe #(.W(A), .N(7 * LR)) u_drn (
    .clk(clk), .en(en), .d(rel_neg), .q(rot_ang[7]));

  // chain of planar rotations
  for (genvar k = 0; k < NUM_ROT; k++) begin : g_rot
    prc_sincos #(.ANGLE_BITS(A), .COORD_FRAC_BITS(F)) u_sc (
      .clk(clk), .en(en), .ang(rot_ang[k]), .c(rc[k]), .s(rs[k]));
    if (ROT_XY[k]) begin : g_xy
      prc_rot #(.COORD_FRAC_BITS(F)) u_rot (
        .clk(clk), .en(en), .u(vx[k]), .w(vy[k]), .c(rc[k]), .s(rs[k]),
        .nu(vx[k+1]), .nw(vy[k+1]));
      prc_pipe #(.W(CW), .N(LR)) u_hold (.clk(clk), .en(en), .d(vz[k]), .q(vz[k+1]));
    end else begin : g_xz
      prc_rot #(.COORD_FRAC_BITS(F)) u_rot (
        .clk(clk), .en(en), .u(vx[k]), .w(vz[k]), .c(rc[k]), .s(rs[k]),
        .nu(vx[k+1]), .nw(vz[k+1]));
      prc_pipe #(.W(CW), .N(LR)) u_hold (.clk(clk), .en(en), .d(vy[k]), .q(vy[k+1]));
    end
  end

  // result fields
  assign vec_x = FIELD_W'(vx[NUM_ROT]);
  assign vec_y = FIELD_W'(vy[NUM_ROT]);
  assign vec_z = FIELD_W'(vz[NUM_ROT]);

`ifndef SYNTHESIS
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("valid line moved while stalled");
  a_pop_enters: assert property (@(posedge clk) disable iff (rst)
    pop |=> vld[0])
    else $error("popped item did not enter the chain");
  a_reset_clears: assert property (@(posedge clk)
    rst |=> vld == '0)
    else $error("valid line not cleared by reset");
`endif

endmodule

@@ rtl/pointing_rotation_chain_top.sv @@
// Pointing rotation chain.
// Input channel s_axis carries one item per sample: five 32-bit binary angles
// (sun polar, sun azimuth, precession opening, precession phase, spin phase).
// Output channel m_axis carries the rotated unit vector as three signed
// Q1.COORD_FRAC_BITS words. The spin opening angle is loaded through
// cfg_we/cfg_wdata; the user must load it only while no item is in flight,
// as the block does not enforce this. Throughput: one item per cycle while
// m_axis is not stalled. A four-entry queue takes items in front of the
// compute chain, a fully pipelined set of cordic units with 32 micro-rotation
// stages each. Items pass through four cordic passes in series: sine/cosine
// of the sun angles, two vectoring passes for the reference angle, and the
// sine/cosine for the first rotation, followed by eight rotations.
// When m_axis_tready is low with a result waiting, the whole chain holds and
// the queue keeps taking items until it is full.
// Synchronous reset empties the queue and the chain and sets spin opening to 0.
module pointing_rotation_chain_top #(
  parameter int ANGLE_BITS      = prc_pkg::ANGLE_BITS_DEF,
  parameter int COORD_FRAC_BITS = prc_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic                                           clk,
  input  logic                                           rst,
  input  logic                                           cfg_we,
  input  logic [prc_pkg::FIELD_W-1:0]                    cfg_wdata,
  input  logic                                           s_axis_tvalid,
  output logic                                           s_axis_tready,
  // sun_polar, sun_azimuth, precession_opening, precession_phase, spin_phase
  input  logic [prc_pkg::IN_FIELDS*prc_pkg::FIELD_W-1:0]  s_axis_tdata,
  output logic                                           m_axis_tvalid,
  input  logic                                           m_axis_tready,
  // vec_x, vec_y, vec_z
  output logic [prc_pkg::OUT_FIELDS*prc_pkg::FIELD_W-1:0] m_axis_tdata
);
  import prc_pkg::*;

  localparam int A = ANGLE_BITS;

  logic [FIELD_W-1:0] spin_opening;
  logic [A-1:0]       spin_open_neg;
  logic               head_valid;
  logic               pop;
  logic [A-1:0]       polar;
  logic [A-1:0]       azimuth;
  logic [A-1:0]       prec_open_neg;
  logic [A-1:0]       prec_phase_neg;
  logic [A-1:0]       spin_phase_neg;
  logic [FIELD_W-1:0] vec_x;
  logic [FIELD_W-1:0] vec_y;
  logic [FIELD_W-1:0] vec_z;

  // spin opening register
  always_ff @(posedge clk) begin
    if (rst) begin
      spin_opening <= '0;
    end else if (cfg_we) begin
      spin_opening <= cfg_wdata;
    end
  end

  assign spin_open_neg = A'(-(A'($signed(spin_opening))));

  prc_front #(.ANGLE_BITS(A)) u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_data(s_axis_tdata),
    .pop(pop), .head_valid(head_valid),
    .polar(polar), .azimuth(azimuth), .prec_open_neg(prec_open_neg),
    .prec_phase_neg(prec_phase_neg), .spin_phase_neg(spin_phase_neg));

  prc_back #(.ANGLE_BITS(A), .COORD_FRAC_BITS(COORD_FRAC_BITS)) u_back (
    .clk(clk), .rst(rst), .spin_open_neg(spin_open_neg),
    .head_valid(head_valid), .pop(pop),
    .polar(polar), .azimuth(azimuth), .prec_open_neg(prec_open_neg),
    .prec_phase_neg(prec_phase_neg), .spin_phase_neg(spin_phase_neg),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z));

  assign m_axis_tdata = {vec_z, vec_y, vec_x};

endmodule
